// ===== rtl/core/wmm_pkg.sv =====
// Package for the window min/max filter: payload structs and fixed constants.
// Has no dependencies; wmm_lane and the top level import it.
package wmm_pkg;

   localparam int unsigned PIX_W = 32;
   localparam logic [7:0] CHAN_MAX = 8'd255;
   localparam logic [7:0] CHAN_MIN = 8'd0;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_TAKE_MAX = 2'd1;
   localparam logic [1:0] REG_WIDTH = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_last;
   } rsp_payload_type;

   // One lane's compare command.
   typedef struct packed {
      logic first;
      logic take_max;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/wmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wmm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/wmm_lane.sv =====
// One channel lane: running min or max of a stream of 8-bit samples.
// Depends on wmm_pkg.
module wmm_lane
   import wmm_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  lane_ctrl_type ctrl,
   input  logic [7:0]    sample,
   output logic [7:0]    best
);
   logic [7:0] best_ff;
   logic [7:0] best_in;
   logic [7:0] seed;

   always_comb begin
      seed = ctrl.take_max ? CHAN_MIN : CHAN_MAX;
      if (ctrl.first) begin
         seed = ctrl.take_max ? CHAN_MIN : CHAN_MAX;
      end else begin
         seed = best_ff;
      end
      if (ctrl.take_max) begin
         best_in = (sample > seed) ? sample : seed;
      end else begin
         best_in = (sample < seed) ? sample : seed;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;
endmodule

// ===== rtl/core/window_min_max_filter_top.sv =====
// Window min/max filter top level: line store, window sequencer, four lanes, merge.
// Depends on wmm_pkg, wmm_ram and wmm_lane.
// A result's window of (2r+1)^2 pixels, r being the effective radius, is read a pixel a cycle,
// then passes the lanes, the tail state and the output register; no new transaction is taken
// while a result is in progress or waiting to be taken.
// Reset is synchronous and restores register defaults and the frame position.
module window_min_max_filter_top
   import wmm_pkg::*;
#(
   parameter int unsigned MAX_RADIUS = 8,
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned CHANNELS   = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [10:0]     csr_data
);
   localparam int unsigned RING  = 2 * MAX_RADIUS + 2;
   localparam int unsigned DEPTH = RING * MAX_WIDTH;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned RW    = $clog2(RING);
   localparam int unsigned XW    = $clog2(MAX_WIDTH);
   localparam logic [10:0] MAX_H = 11'd1024;
   localparam int unsigned MOD_K = 24;
   localparam int unsigned MOD_M = (1 << MOD_K) / RING + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_TAIL = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  radius_ff;
   logic        take_max_ff;
   logic [10:0] width_ff, height_ff;
   logic [10:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic        complete_ff;
   logic signed [11:0] dy_ff, dx_ff;
   logic [1:0]  tail_ff;
   logic        first_ff, first_d_ff, valid_d_ff;
   logic        last_ff;
   rsp_payload_type rsp_ff;

   // Row position within the ring, by reciprocal multiplication.
   function automatic logic [10:0] ring_row(logic [10:0] row);
      logic [63:0] q;
      q = (64'(row) * 64'(MOD_M)) >> MOD_K;
      return 11'(64'(row) - q * 64'(RING));
   endfunction

   // Effective configuration.
   logic [10:0] w_eff, h_eff;
   logic [3:0]  r_eff;
   always_comb begin
      r_eff = (32'(radius_ff) > MAX_RADIUS) ? 4'(MAX_RADIUS) : radius_ff;
      w_eff = (width_ff == 11'd0) ? 11'd1
            : ((32'(width_ff) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_ff);
      h_eff = (height_ff == 11'd0) ? 11'd1 : ((height_ff > MAX_H) ? MAX_H : height_ff);
   end

   logic accept_req, is_pixel, store_pix;
   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid;
   assign csr_ready  = (state_ff == ST_IDLE) && !rsp_valid;
   assign accept_req = req_valid && req_ready;
   assign is_pixel   = req_payload.req_type == REQ_PIXEL;
   assign store_pix  = accept_req && is_pixel && !complete_ff;

   // Input position after the current transaction.
   logic [10:0] nin_col, nin_row;
   logic        ncomplete;
   always_comb begin
      nin_col = in_col_ff;
      nin_row = in_row_ff;
      ncomplete = complete_ff;
      if (store_pix) begin
         nin_col = in_col_ff + 11'd1;
         if (nin_col >= w_eff) begin
            nin_col = 11'd0;
            nin_row = in_row_ff + 11'd1;
            if (nin_row >= h_eff) begin
               nin_row = 11'd0;
               ncomplete = 1'b1;
            end
         end
      end
   end

   // Readiness of the next result: compare (row, col) pairs, equivalent to linear index.
   logic [11:0] ny, nx;
   logic        ready_out, gives_result;
   always_comb begin
      ny = 12'(out_row_ff) + 12'(r_eff);
      nx = 12'(out_col_ff) + 12'(r_eff);
      if (ny > 12'(h_eff) - 12'd1) ny = 12'(h_eff) - 12'd1;
      if (nx > 12'(w_eff) - 12'd1) nx = 12'(w_eff) - 12'd1;
      ready_out = ncomplete || (12'(nin_row) > ny)
                || ((12'(nin_row) == ny) && (12'(nin_col) > nx));
      gives_result = accept_req && (is_pixel || complete_ff) && ready_out
                   && (out_row_ff < h_eff) && (out_col_ff < w_eff);
   end

   // Window read address with edge clamping.
   logic signed [12:0] sy_s, sx_s;
   logic [10:0] sy, sx;
   logic [AW-1:0] rd_addr, wr_addr;
   always_comb begin
      sy_s = 13'(signed'({1'b0, out_row_ff})) + 13'(dy_ff);
      sx_s = 13'(signed'({1'b0, out_col_ff})) + 13'(dx_ff);
      if (sy_s < 0) sy = 11'd0;
      else if (sy_s >= 13'(signed'({2'b0, h_eff}))) sy = h_eff - 11'd1;
      else sy = sy_s[10:0];
      if (sx_s < 0) sx = 11'd0;
      else if (sx_s >= 13'(signed'({2'b0, w_eff}))) sx = w_eff - 11'd1;
      else sx = sx_s[10:0];
      rd_addr = AW'(32'(ring_row(sy)) * MAX_WIDTH + 32'(sx[XW-1:0]));
      wr_addr = AW'(32'(ring_row(in_row_ff)) * MAX_WIDTH + 32'(in_col_ff[XW-1:0]));
   end

   logic [PIX_W-1:0] rd_data;
   wmm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (store_pix),
      .wr_addr (wr_addr),
      .wr_data ({req_payload.in_alpha, req_payload.in_blue,
                 req_payload.in_green, req_payload.in_red}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic scanning, scan_end;
   assign scanning = state_ff == ST_SCAN;
   assign scan_end = scanning && (dy_ff == 12'(r_eff)) && (dx_ff == 12'(r_eff));

   lane_ctrl_type lane_ctrl;
   assign lane_ctrl = '{first: first_d_ff, take_max: take_max_ff};
   logic [7:0] best [4];
   for (genvar c = 0; c < 4; c++) begin : g_lane
      wmm_lane u_lane (
         .clock  (clock),
         .en     (valid_d_ff),
         .ctrl   (lane_ctrl),
         .sample (rd_data[8*c +: 8]),
         .best   (best[c])
      );
   end

   // Merge stage: pack the lane results, zeroing channels beyond CHANNELS.
   rsp_payload_type merged;
   always_comb begin
      merged.out_red    = (CHANNELS > 0) ? best[0] : 8'd0;
      merged.out_green  = (CHANNELS > 1) ? best[1] : 8'd0;
      merged.out_blue   = (CHANNELS > 2) ? best[2] : 8'd0;
      merged.out_alpha  = (CHANNELS > 3) ? best[3] : 8'd0;
      merged.frame_last = last_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (gives_result) state_in = ST_SCAN;
         ST_SCAN: if (scan_end) state_in = ST_TAIL;
         ST_TAIL: if (tail_ff == 2'd1) state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= 4'd1;
         take_max_ff  <= 1'b0;
         width_ff     <= 11'd1024;
         height_ff    <= 11'd1024;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_d_ff   <= 1'b0;
         first_d_ff   <= 1'b0;
         first_ff     <= 1'b0;
         tail_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         valid_d_ff <= scanning;
         first_d_ff <= scanning && first_ff;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_RADIUS:   radius_ff   <= csr_data[3:0];
               REG_TAKE_MAX: take_max_ff <= csr_data[0];
               REG_WIDTH:    width_ff    <= csr_data;
               REG_HEIGHT:   height_ff   <= csr_data;
               default:      radius_ff   <= radius_ff;
            endcase
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            complete_ff <= 1'b0;
         end else if (accept_req) begin
            in_col_ff   <= nin_col;
            in_row_ff   <= nin_row;
            complete_ff <= ncomplete;
         end
         if (gives_result) begin
            dy_ff    <= -12'(r_eff);
            dx_ff    <= -12'(r_eff);
            first_ff <= 1'b1;
            last_ff  <= (out_col_ff == w_eff - 11'd1) && (out_row_ff == h_eff - 11'd1);
         end
         if (scanning) begin
            first_ff <= 1'b0;
            if (dx_ff == 12'(r_eff)) begin
               dx_ff <= -12'(r_eff);
               dy_ff <= dy_ff + 12'sd1;
            end else begin
               dx_ff <= dx_ff + 12'sd1;
            end
            tail_ff <= 2'd2;
         end
         if (state_ff == ST_TAIL) tail_ff <= tail_ff - 2'd1;
         if (state_ff == ST_OUT) begin
            rsp_ff       <= merged;
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               complete_ff <= 1'b0;
            end else if (out_col_ff + 11'd1 >= w_eff) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 11'd1;
            end else begin
               out_col_ff <= out_col_ff + 11'd1;
            end
         end
      end
   end
endmodule
